FILE: rtl/polled_temperature_threshold_switch_unit_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the polled temperature threshold switch
// Concurrent property wrappers clocked on clk_i, disabled during reset.
// ----------------------------------------------------------------------------
`ifndef POLLED_TEMPERATURE_THRESHOLD_SWITCH_UNIT_DEFINES_SVH
`define POLLED_TEMPERATURE_THRESHOLD_SWITCH_UNIT_DEFINES_SVH

// same-cycle implication
`define PTTS_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("ptts: implication check failed");

// next-cycle implication
`define PTTS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("ptts: next-cycle check failed");

`endif

FILE: rtl/ptts_pkg.sv
// ----------------------------------------------------------------------------
// ptts_pkg
// Constants and codes for the polled temperature threshold switch.
// ----------------------------------------------------------------------------
package ptts_pkg;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;
  localparam int unsigned TempW    = 16;
  localparam int unsigned ThrW     = 15;
  localparam int unsigned PeriodW  = 16;

  // register indexes
  localparam logic [CfgIdxW-1:0] REG_THRESHOLD = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_HEATUP    = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_COOLDOWN  = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_TRIGGER   = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_INVERT    = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_ARM_REQ   = 3'd5;

  // level states
  localparam logic [1:0] LVL_UNKNOWN = 2'd0;
  localparam logic [1:0] LVL_LOW     = 2'd1;
  localparam logic [1:0] LVL_HIGH    = 2'd2;

  // trigger kinds
  localparam logic [1:0] TRIG_LEVEL   = 2'd0;
  localparam logic [1:0] TRIG_RISING  = 2'd1;
  localparam logic [1:0] TRIG_FALLING = 2'd2;

  // item modes
  localparam logic MODE_TICK = 1'b0;
  localparam logic MODE_ARM  = 1'b1;

  // reset values
  localparam logic [ThrW-1:0]    THRESHOLD_RST = 15'd800;
  localparam logic [PeriodW-1:0] HEATUP_RST    = 16'd15;
  localparam logic [PeriodW-1:0] COOLDOWN_RST  = 16'd60;
  localparam logic [PeriodW-1:0] SECONDS_MAX   = 16'hFFFF;

endpackage

FILE: rtl/polled_temperature_threshold_switch_unit.sv
// ----------------------------------------------------------------------------
// polled_temperature_threshold_switch_unit
// Threshold switch driven by one-second ticks and arm commands.
// ----------------------------------------------------------------------------
// Each transfer on the input channel is either a one-second tick carrying the
// hottest temperature and the present switch level, or an arm command; each
// gives exactly one result transfer. An item is held in an input register,
// evaluated by a single compare-and-update stage against the seconds counter,
// level state and arm flag, and then lands in the result register; one item is
// taken every cycle while the result side does not stall. The user must write
// the configuration registers through cfg_we_i/cfg_idx_i/cfg_data_i only while
// no item is in flight; the block itself does not enforce this.
// ----------------------------------------------------------------------------
`include "polled_temperature_threshold_switch_unit_defines.svh"

module polled_temperature_threshold_switch_unit (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // configuration
  input  logic                                 cfg_we_i,
  input  logic [ptts_pkg::CfgIdxW-1:0]         cfg_idx_i,
  input  logic [ptts_pkg::CfgDataW-1:0]        cfg_data_i,
  // input channel
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic                                 mode_i,
  input  logic signed [ptts_pkg::TempW-1:0]    temperature_i,
  input  logic                                 switch_now_i,
  input  logic                                 arm_on_i,
  // result channel
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic                                 write_switch_o,
  output logic                                 switch_level_o,
  output logic                                 is_armed_o,
  output logic [1:0]                           level_state_o
);

  // configuration registers
  logic [ptts_pkg::ThrW-1:0]    thr_q;
  logic [ptts_pkg::PeriodW-1:0] heatup_q;
  logic [ptts_pkg::PeriodW-1:0] cooldown_q;
  logic [1:0]                   trig_q;
  logic                         invert_q;
  logic                         arm_req_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q      <= ptts_pkg::THRESHOLD_RST;
      heatup_q   <= ptts_pkg::HEATUP_RST;
      cooldown_q <= ptts_pkg::COOLDOWN_RST;
      trig_q     <= ptts_pkg::TRIG_LEVEL;
      invert_q   <= 1'b0;
      arm_req_q  <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        ptts_pkg::REG_THRESHOLD: thr_q      <= cfg_data_i[ptts_pkg::ThrW-1:0];
        ptts_pkg::REG_HEATUP:    heatup_q   <= cfg_data_i[ptts_pkg::PeriodW-1:0];
        ptts_pkg::REG_COOLDOWN:  cooldown_q <= cfg_data_i[ptts_pkg::PeriodW-1:0];
        ptts_pkg::REG_TRIGGER:   trig_q     <= cfg_data_i[1:0];
        ptts_pkg::REG_INVERT:    invert_q   <= cfg_data_i[0];
        ptts_pkg::REG_ARM_REQ:   arm_req_q  <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // input register
  logic                             in_valid_q;
  logic                             mode_q;
  logic signed [ptts_pkg::TempW-1:0] temp_q;
  logic                             sw_now_q;
  logic                             arm_on_q;

  logic out_ready;
  logic s1_fire;
  logic in_fire;

  assign out_ready  = !out_valid_o || !out_stall_i;
  assign s1_fire    = in_valid_q && out_ready;
  assign in_stall_o = in_valid_q && !out_ready;
  assign in_fire    = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_fire) begin
      in_valid_q <= 1'b1;
    end else if (s1_fire) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      mode_q   <= mode_i;
      temp_q   <= temperature_i;
      sw_now_q <= switch_now_i;
      arm_on_q <= arm_on_i;
    end
  end

  // evaluation state
  logic [ptts_pkg::PeriodW-1:0] cnt_q, cnt_d;
  logic [1:0]                   level_q, level_d;
  logic                         use_cd_q, use_cd_d;
  logic                         armed_q, armed_d;

  logic [ptts_pkg::PeriodW-1:0] cnt_inc;
  logic [ptts_pkg::PeriodW-1:0] period;
  logic                         test;
  logic [ptts_pkg::ThrW-1:0]    temp_pos;
  logic [1:0]                   new_lvl;
  logic                         change;
  logic                         want;
  logic                         val;
  logic                         edge_trig;
  logic                         eff_armed;
  logic                         fire;
  logic                         out_val;

  always_comb begin
    cnt_inc   = (cnt_q == ptts_pkg::SECONDS_MAX) ? cnt_q : cnt_q + 1'b1;
    period    = use_cd_q ? cooldown_q : heatup_q;
    test      = (mode_q == ptts_pkg::MODE_TICK) && (cnt_inc >= period);
    temp_pos  = temp_q[ptts_pkg::TempW-1] ? '0 : temp_q[ptts_pkg::ThrW-1:0];
    new_lvl   = (temp_pos >= thr_q) ? ptts_pkg::LVL_HIGH : ptts_pkg::LVL_LOW;
    change    = test && (new_lvl != level_q);
    eff_armed = !arm_req_q || armed_q;
    edge_trig = (trig_q == ptts_pkg::TRIG_RISING) || (trig_q == ptts_pkg::TRIG_FALLING);

    case (trig_q)
      ptts_pkg::TRIG_RISING: begin
        want = (level_q == ptts_pkg::LVL_LOW) && (new_lvl == ptts_pkg::LVL_HIGH);
        val  = 1'b1;
      end
      ptts_pkg::TRIG_FALLING: begin
        want = (level_q == ptts_pkg::LVL_HIGH) && (new_lvl == ptts_pkg::LVL_LOW);
        val  = 1'b0;
      end
      default: begin
        want = 1'b1;
        val  = (new_lvl == ptts_pkg::LVL_HIGH);
      end
    endcase

    fire    = change && want && eff_armed;
    out_val = val ^ invert_q;

    cnt_d    = cnt_q;
    level_d  = level_q;
    use_cd_d = use_cd_q;
    armed_d  = armed_q;
    if (mode_q == ptts_pkg::MODE_ARM) begin
      armed_d = arm_on_q;
    end else begin
      cnt_d = test ? '0 : cnt_inc;
      if (change) begin
        level_d  = new_lvl;
        use_cd_d = (new_lvl == ptts_pkg::LVL_HIGH);
      end
      if (fire && arm_req_q && edge_trig) begin
        armed_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q    <= ptts_pkg::SECONDS_MAX;
      level_q  <= ptts_pkg::LVL_UNKNOWN;
      use_cd_q <= 1'b0;
      armed_q  <= 1'b0;
    end else if (s1_fire) begin
      cnt_q    <= cnt_d;
      level_q  <= level_d;
      use_cd_q <= use_cd_d;
      armed_q  <= armed_d;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (s1_fire) begin
      out_valid_o <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire) begin
      write_switch_o <= fire && (out_val != sw_now_q);
      switch_level_o <= fire && out_val;
      is_armed_o     <= !arm_req_q || armed_d;
      level_state_o  <= level_d;
    end
  end

  // checks
  `PTTS_ASSERT_NEXT(a_test_clears_count, s1_fire && test, cnt_q == '0)
  `PTTS_ASSERT_NEXT(a_arm_cmd_sets_flag, s1_fire && (mode_q == ptts_pkg::MODE_ARM),
                    armed_q == $past(arm_on_q))
  `PTTS_ASSERT_NEXT(a_one_shot_disarm, s1_fire && fire && arm_req_q && edge_trig,
                    !armed_q && !is_armed_o)
  `PTTS_ASSERT_IMPL(a_write_has_level, out_valid_o && write_switch_o,
                    level_state_o != ptts_pkg::LVL_UNKNOWN)

endmodule

FILE: tb/polled_temperature_threshold_switch_unit_tb.sv
// ----------------------------------------------------------------------------
// Polled temperature threshold switch testbench
// Drives ticks and arm commands through the valid/stall input channel, with
// random gaps on both sides, and predicts every switch decision in a local
// model of the counter, level state and arm flag. A short directed table
// covers threshold and temperature extremes, negative readings, each trigger
// kind, one-shot disarm and inversion; random phases follow, each with its
// own register setting. Results are compared field by field in order.
// ----------------------------------------------------------------------------
module polled_temperature_threshold_switch_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ptts_pkg::*;

  localparam logic [1:0] TRIG_RESERVED = 2'd3;
  localparam int NO_CFG = -1;
  localparam int PHASES = 8;
  localparam int PHASE_ITEMS = 200;

  typedef struct packed {
    logic              mode;
    logic signed [15:0] temperature;
    logic              switch_now;
    logic              arm_on;
  } reading_t;

  typedef struct packed {
    logic       write_switch;
    logic       switch_level;
    logic       is_armed;
    logic [1:0] level_state;
  } switch_result_t;

  typedef struct packed {
    logic [ThrW-1:0]    thr;
    logic [PeriodW-1:0] heat;
    logic [PeriodW-1:0] cool;
    logic [1:0]         trig;
    logic               inv;
    logic               arm_req;
  } settings_t;

  typedef struct packed {
    int             cfg;
    logic           mode;
    logic [15:0]    temperature;
    logic           switch_now;
    logic           arm_on;
    logic           check;
    switch_result_t expect_res;
  } dir_row_t;

  localparam logic [CfgIdxW-1:0] REG_ORDER [6] = '{
    REG_THRESHOLD, REG_HEATUP, REG_COOLDOWN, REG_TRIGGER, REG_INVERT, REG_ARM_REQ
  };

  localparam settings_t DIR_SETTINGS [5] = '{
    '{15'h7FFF, 16'd0, 16'd0, TRIG_LEVEL,    1'b0, 1'b0},
    '{15'h0000, 16'd0, 16'd0, TRIG_RISING,   1'b1, 1'b1},
    '{15'h4000, 16'd0, 16'd0, TRIG_FALLING,  1'b0, 1'b1},
    '{15'h4000, 16'd0, 16'd0, TRIG_RESERVED, 1'b0, 1'b1},
    '{15'h4000, 16'd2, 16'd3, TRIG_RESERVED, 1'b1, 1'b0}
  };

  // expect_res is used only where check is set
  localparam dir_row_t DIRECTED [23] = '{
    '{NO_CFG, MODE_TICK, 16'd800,  1'b0, 1'b0, 1'b1, '{1'b1, 1'b1, 1'b1, LVL_HIGH}},
    '{NO_CFG, MODE_TICK, 16'h8000, 1'b1, 1'b0, 1'b1, '{1'b0, 1'b0, 1'b1, LVL_HIGH}},
    '{NO_CFG, MODE_ARM,  16'h0000, 1'b0, 1'b1, 1'b1, '{1'b0, 1'b0, 1'b1, LVL_HIGH}},
    '{0,      MODE_TICK, 16'h7FFF, 1'b1, 1'b0, 1'b1, '{1'b0, 1'b0, 1'b1, LVL_HIGH}},
    '{NO_CFG, MODE_TICK, 16'h7FFE, 1'b1, 1'b0, 1'b1, '{1'b1, 1'b0, 1'b1, LVL_LOW}},
    '{NO_CFG, MODE_TICK, 16'hFFFF, 1'b0, 1'b1, 1'b1, '{1'b0, 1'b0, 1'b1, LVL_LOW}},
    '{1,      MODE_TICK, 16'h8000, 1'b1, 1'b0, 1'b0, '{1'b0, 1'b0, 1'b0, LVL_UNKNOWN}},
    '{NO_CFG, MODE_TICK, 16'h0000, 1'b0, 1'b0, 1'b1, '{1'b0, 1'b0, 1'b0, LVL_HIGH}},
    '{NO_CFG, MODE_ARM,  16'hFFFF, 1'b1, 1'b1, 1'b1, '{1'b0, 1'b0, 1'b1, LVL_HIGH}},
    '{2,      MODE_TICK, 16'h4000, 1'b0, 1'b0, 1'b1, '{1'b0, 1'b0, 1'b1, LVL_HIGH}},
    '{NO_CFG, MODE_TICK, 16'h3FFF, 1'b1, 1'b0, 1'b0, '{1'b0, 1'b0, 1'b0, LVL_UNKNOWN}},
    '{NO_CFG, MODE_TICK, 16'h5000, 1'b0, 1'b0, 1'b0, '{1'b0, 1'b0, 1'b0, LVL_UNKNOWN}},
    '{NO_CFG, MODE_ARM,  16'h0000, 1'b0, 1'b1, 1'b0, '{1'b0, 1'b0, 1'b0, LVL_UNKNOWN}},
    '{NO_CFG, MODE_TICK, 16'h8000, 1'b0, 1'b0, 1'b0, '{1'b0, 1'b0, 1'b0, LVL_UNKNOWN}},
    '{NO_CFG, MODE_ARM,  16'h0000, 1'b0, 1'b0, 1'b1, '{1'b0, 1'b0, 1'b0, LVL_LOW}},
    '{3,      MODE_TICK, 16'h7FFF, 1'b0, 1'b0, 1'b1, '{1'b0, 1'b0, 1'b0, LVL_HIGH}},
    '{NO_CFG, MODE_ARM,  16'h0000, 1'b0, 1'b1, 1'b1, '{1'b0, 1'b0, 1'b1, LVL_HIGH}},
    '{NO_CFG, MODE_TICK, 16'h0000, 1'b1, 1'b0, 1'b0, '{1'b0, 1'b0, 1'b0, LVL_UNKNOWN}},
    '{4,      MODE_TICK, 16'h7FFF, 1'b0, 1'b0, 1'b1, '{1'b0, 1'b0, 1'b1, LVL_LOW}},
    '{NO_CFG, MODE_TICK, 16'h7FFF, 1'b0, 1'b0, 1'b0, '{1'b0, 1'b0, 1'b0, LVL_UNKNOWN}},
    '{NO_CFG, MODE_TICK, 16'h0000, 1'b0, 1'b0, 1'b0, '{1'b0, 1'b0, 1'b0, LVL_UNKNOWN}},
    '{NO_CFG, MODE_TICK, 16'h0000, 1'b0, 1'b0, 1'b0, '{1'b0, 1'b0, 1'b0, LVL_UNKNOWN}},
    '{NO_CFG, MODE_TICK, 16'h0000, 1'b0, 1'b0, 1'b0, '{1'b0, 1'b0, 1'b0, LVL_UNKNOWN}}
  };

  logic                       clk_i = 1'b0;
  logic                       rst_ni = 1'b0;
  logic                       cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0]         cfg_idx_i = '0;
  logic [CfgDataW-1:0]        cfg_data_i = '0;
  logic                       in_valid_i = 1'b0;
  logic                       in_stall_o;
  logic                       mode_i = MODE_TICK;
  logic signed [TempW-1:0]    temperature_i = '0;
  logic                       switch_now_i = 1'b0;
  logic                       arm_on_i = 1'b0;
  logic                       out_valid_o;
  logic                       out_stall_i = 1'b0;
  logic                       write_switch_o;
  logic                       switch_level_o;
  logic                       is_armed_o;
  logic [1:0]                 level_state_o;

  // typed expectation traveling with a directed transfer
  logic           row_check = 1'b0;
  switch_result_t row_expect = '0;

  int unsigned send_gap_pct = 0;
  int unsigned stall_pct = 0;
  int          fail_count = 0;

  switch_result_t switch_results_due [$];

  // local copy of the registers and decision state
  settings_t    regs = '{THRESHOLD_RST, HEATUP_RST, COOLDOWN_RST, TRIG_LEVEL, 1'b0, 1'b0};
  logic [15:0]  sec_count = SECONDS_MAX;
  logic [1:0]   lvl_state = LVL_UNKNOWN;
  logic         cool_sel = 1'b0;
  logic         arm_flag = 1'b0;

  polled_temperature_threshold_switch_unit dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .mode_i         (mode_i),
    .temperature_i  (temperature_i),
    .switch_now_i   (switch_now_i),
    .arm_on_i       (arm_on_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .write_switch_o (write_switch_o),
    .switch_level_o (switch_level_o),
    .is_armed_o     (is_armed_o),
    .level_state_o  (level_state_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  function automatic switch_result_t predict_switch(input reading_t rd);
    switch_result_t     res;
    logic [PeriodW-1:0] period;
    logic [15:0]        temp;
    logic [1:0]         next_lvl;
    logic               want;
    logic               val;
    logic               is_edge;
    res = '0;
    if (rd.mode == MODE_ARM) begin
      arm_flag = rd.arm_on;
    end else begin
      period = cool_sel ? regs.cool : regs.heat;
      if (sec_count != SECONDS_MAX) sec_count = sec_count + 16'd1;
      if (sec_count >= period) begin
        temp = rd.temperature[15] ? 16'd0 : rd.temperature;
        next_lvl = (temp >= {1'b0, regs.thr}) ? LVL_HIGH : LVL_LOW;
        sec_count = '0;
        if (next_lvl != lvl_state) begin
          want = 1'b0;
          val = 1'b0;
          is_edge = (regs.trig == TRIG_RISING) || (regs.trig == TRIG_FALLING);
          case (regs.trig)
            TRIG_RISING: begin
              if (lvl_state == LVL_LOW && next_lvl == LVL_HIGH) begin
                want = 1'b1;
                val = 1'b1;
              end
            end
            TRIG_FALLING: begin
              if (lvl_state == LVL_HIGH && next_lvl == LVL_LOW) want = 1'b1;
            end
            default: begin
              want = 1'b1;
              val = (next_lvl == LVL_HIGH);
            end
          endcase
          if (want && (!regs.arm_req || arm_flag)) begin
            if (regs.arm_req && is_edge) arm_flag = 1'b0;
            val = val ^ regs.inv;
            res.switch_level = val;
            res.write_switch = (val != rd.switch_now);
          end
          cool_sel = (next_lvl == LVL_HIGH);
          lvl_state = next_lvl;
        end
      end
    end
    res.is_armed = !regs.arm_req || arm_flag;
    res.level_state = lvl_state;
    return res;
  endfunction

  function automatic settings_t random_settings();
    settings_t s;
    s.thr = ($urandom_range(3) == 0) ? ($urandom_range(1) ? '1 : '0)
                                     : ThrW'($urandom_range(32767));
    s.heat = ($urandom_range(7) == 0) ? PeriodW'(65535) : PeriodW'($urandom_range(4));
    s.cool = ($urandom_range(7) == 0) ? PeriodW'(65535) : PeriodW'($urandom_range(4));
    s.trig = 2'($urandom_range(3));
    s.inv = 1'($urandom_range(1));
    s.arm_req = 1'($urandom_range(1));
    return s;
  endfunction

  function automatic reading_t random_reading();
    reading_t    rd;
    int unsigned pick;
    rd.mode = ($urandom_range(9) == 0) ? MODE_ARM : MODE_TICK;
    rd.switch_now = 1'($urandom_range(1));
    rd.arm_on = 1'($urandom_range(1));
    pick = $urandom_range(9);
    if (pick < 5) begin
      // hover around the threshold so the level keeps flipping
      rd.temperature = 16'(int'(regs.thr) + int'($urandom_range(6)) - 3);
    end else if (pick < 8) begin
      rd.temperature = 16'($urandom);
    end else begin
      case ($urandom_range(3))
        0:       rd.temperature = 16'h8000;
        1:       rd.temperature = 16'h7FFF;
        2:       rd.temperature = 16'hFFFF;
        default: rd.temperature = 16'h0000;
      endcase
    end
    return rd;
  endfunction

  task automatic send_reading(input reading_t rd, input logic chk, input switch_result_t exp_res);
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    mode_i <= rd.mode;
    temperature_i <= rd.temperature;
    switch_now_i <= rd.switch_now;
    arm_on_i <= rd.arm_on;
    row_check <= chk;
    row_expect <= exp_res;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (switch_results_due.size() != 0);
    repeat (3) @(posedge clk_i);
  endtask

  task automatic apply_settings(input settings_t s);
    logic [CfgDataW-1:0] word;
    drain();
    foreach (REG_ORDER[k]) begin
      case (REG_ORDER[k])
        REG_THRESHOLD: word = CfgDataW'(s.thr);
        REG_HEATUP:    word = s.heat;
        REG_COOLDOWN:  word = s.cool;
        REG_TRIGGER:   word = CfgDataW'(s.trig);
        REG_INVERT:    word = CfgDataW'(s.inv);
        default:       word = CfgDataW'(s.arm_req);
      endcase
      cfg_we_i <= 1'b1;
      cfg_idx_i <= REG_ORDER[k];
      cfg_data_i <= word;
      @(posedge clk_i);
    end
    cfg_we_i <= 1'b0;
    regs = s;
  endtask

  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk_i) begin : result_check
    switch_result_t want;
    switch_result_t got;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        want = predict_switch('{mode_i, temperature_i, switch_now_i, arm_on_i});
        switch_results_due.push_back(row_check ? row_expect : want);
      end
      if (out_valid_o && !out_stall_i) begin
        got = '{write_switch_o, switch_level_o, is_armed_o, level_state_o};
        if (switch_results_due.size() == 0) begin
          $error("result transfer with nothing outstanding");
          fail_count++;
        end else begin
          want = switch_results_due.pop_front();
          if (got.write_switch !== want.write_switch) begin
            $error("write_switch: expected %0d, got %0d", want.write_switch, got.write_switch);
            fail_count++;
          end
          if (got.switch_level !== want.switch_level) begin
            $error("switch_level: expected %0d, got %0d", want.switch_level, got.switch_level);
            fail_count++;
          end
          if (got.is_armed !== want.is_armed) begin
            $error("is_armed: expected %0d, got %0d", want.is_armed, got.is_armed);
            fail_count++;
          end
          if (got.level_state !== want.level_state) begin
            $error("level_state: expected %0d, got %0d", want.level_state, got.level_state);
            fail_count++;
          end
        end
      end
    end
  end

  initial begin
    settings_t s;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    send_gap_pct = 21;
    stall_pct = 73;
    foreach (DIRECTED[i]) begin
      if (DIRECTED[i].cfg != NO_CFG) apply_settings(DIR_SETTINGS[DIRECTED[i].cfg]);
      send_reading('{DIRECTED[i].mode, DIRECTED[i].temperature, DIRECTED[i].switch_now,
                     DIRECTED[i].arm_on}, DIRECTED[i].check, DIRECTED[i].expect_res);
    end
    for (int ph = 0; ph < PHASES; ph++) begin
      if (ph < 3) begin
        send_gap_pct = 21;
        stall_pct = 73;
      end else if (ph < 6) begin
        send_gap_pct = 73;
        stall_pct = 21;
      end else begin
        send_gap_pct = 0;
        stall_pct = 0;
      end
      case (ph)
        1:       s = '{'0, '0, '0, TRIG_LEVEL, 1'b0, 1'b0};
        2:       s = '{'1, 16'd1, '1, TRIG_FALLING, 1'b1, 1'b1};
        4:       s = '{ThrW'($urandom_range(32767)), '1, '0, TRIG_RISING, 1'b0, 1'b1};
        default: s = random_settings();
      endcase
      apply_settings(s);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // hold off until the pipeline is empty
        if (n == PHASE_ITEMS / 2) drain();
        send_reading(random_reading(), 1'b0, '0);
      end
    end
    drain();
    repeat (6) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
